// ===== design/sdsa_pkg.sv =====
// shared types and constants of the disc space allocator
`timescale 1ns / 1ps
`default_nettype none

package sdsa_pkg;

    localparam int unsigned NODE_W   = 5;
    localparam int unsigned DISC_W   = 6;
    localparam int unsigned IMAGE_W  = 16;
    localparam int unsigned BYTES_W  = 44;
    localparam int unsigned GNODE_W  = 4;
    localparam int unsigned GLOBAL_W = 11;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [63:0] LARGE_FACTOR = 64'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_START_NODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DISC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IMAGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_USED  = 2'd3;

    typedef enum logic [1:0] {
        ST_GRANT     = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [GNODE_W-1:0]    grant_node;
        logic [DISC_W-1:0]     grant_disc;
        logic [IMAGE_W-1:0]    grant_image;
        logic [BYTES_W-1:0]    grant_offset;
        logic [BYTES_W-1:0]    grant_length;
        logic [GLOBAL_W-1:0]   global_image;
    } t_result;

endpackage

`default_nettype wire

// ===== design/sdsa_req_if.sv =====
// request channel interface
`timescale 1ns / 1ps
`default_nettype none

interface sdsa_req_if;
    logic        valid;
    logic        ready;
    logic [43:0] request_length;

    modport source (output valid, output request_length, input ready);
    modport sink (input valid, input request_length, output ready);
endinterface

`default_nettype wire

// ===== design/sdsa_res_if.sv =====
// result channel interface
`timescale 1ns / 1ps
`default_nettype none

interface sdsa_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  grant_node;
    logic [5:0]  grant_disc;
    logic [15:0] grant_image;
    logic [43:0] grant_offset;
    logic [43:0] grant_length;
    logic [10:0] global_image;

    modport source (
        output valid, output status, output grant_node, output grant_disc,
        output grant_image, output grant_offset, output grant_length,
        output global_image, input ready
    );
    modport sink (
        input valid, input status, input grant_node, input grant_disc,
        input grant_image, input grant_offset, input grant_length,
        input global_image, output ready
    );
endinterface

`default_nettype wire

// ===== design/sdsa_core.sv =====
// cursor registers, start registers and the single-pass allocation step
`timescale 1ns / 1ps
`default_nettype none

module sdsa_core
    import sdsa_pkg::*;
#(
    parameter int unsigned NODE_COUNT     = 16,
    parameter int unsigned DISCS_PER_NODE = 64,
    parameter int unsigned SMALL_DISCS    = 32,
    parameter logic [63:0] CAPACITY_UNIT  = 64'd1000000000000
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [BYTES_W-1:0]   i_len,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTES_W-1:0]   i_cfg_data,
    output t_result                   o_result
);

    localparam logic [BYTES_W-1:0] CAP_SMALL = BYTES_W'(CAPACITY_UNIT);
    localparam logic [BYTES_W-1:0] CAP_LARGE = BYTES_W'(LARGE_FACTOR * CAPACITY_UNIT);

    logic [NODE_W-1:0]  r_start_node,  n_start_node;
    logic [DISC_W-1:0]  r_start_disc,  n_start_disc;
    logic [IMAGE_W-1:0] r_start_image, n_start_image;
    logic [BYTES_W-1:0] r_start_used,  n_start_used;

    logic [NODE_W-1:0]  r_node,  n_node;
    logic [DISC_W-1:0]  r_disc,  n_disc;
    logic [IMAGE_W-1:0] r_image, n_image;
    logic [BYTES_W-1:0] r_used,  n_used;

    logic [BYTES_W-1:0] len;
    logic               cur_valid;
    logic [BYTES_W-1:0] cap0;
    logic [BYTES_W-1:0] cap1;
    logic [BYTES_W:0]   sum0;
    logic [DISC_W:0]    disc_inc;
    logic               disc_wrap;
    logic [NODE_W-1:0]  node1;
    logic [DISC_W-1:0]  disc1;

    // start registers as they stand after this cycle's write
    always_comb begin
        n_start_node  = r_start_node;
        n_start_disc  = r_start_disc;
        n_start_image = r_start_image;
        n_start_used  = r_start_used;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_NODE:  n_start_node  = i_cfg_data[NODE_W-1:0];
                CFG_START_DISC:  n_start_disc  = i_cfg_data[DISC_W-1:0];
                CFG_START_IMAGE: n_start_image = i_cfg_data[IMAGE_W-1:0];
                CFG_START_USED:  n_start_used  = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // allocation step: first try, then one advance and retry on a fresh disc
    always_comb begin
        len       = (i_len == '0) ? BYTES_W'(1) : i_len;
        cur_valid = (r_node < NODE_W'(NODE_COUNT)) &&
                    ({1'b0, r_disc} < (DISC_W + 1)'(DISCS_PER_NODE));
        cap0      = ({1'b0, r_disc} < (DISC_W + 1)'(SMALL_DISCS)) ? CAP_SMALL : CAP_LARGE;
        sum0      = {1'b0, r_used} + {1'b0, len};
        disc_inc  = {1'b0, r_disc} + (DISC_W + 1)'(1);
        disc_wrap = (disc_inc >= (DISC_W + 1)'(DISCS_PER_NODE));
        disc1     = disc_wrap ? '0 : disc_inc[DISC_W-1:0];
        node1     = disc_wrap ? (r_node + NODE_W'(1)) : r_node;
        cap1      = ({1'b0, disc1} < (DISC_W + 1)'(SMALL_DISCS)) ? CAP_SMALL : CAP_LARGE;

        n_node  = r_node;
        n_disc  = r_disc;
        n_image = r_image;
        n_used  = r_used;

        o_result = '0;

        if (!cur_valid) begin
            o_result.status = ST_INVALID;
        end else if (len > cap0) begin
            o_result.status = ST_TOO_LARGE;
        end else if (sum0 <= {1'b0, cap0}) begin
            o_result.status       = ST_GRANT;
            o_result.grant_node   = r_node[GNODE_W-1:0];
            o_result.grant_disc   = r_disc;
            o_result.grant_image  = r_image;
            o_result.grant_offset = r_used;
            o_result.grant_length = len;
            n_used                = sum0[BYTES_W-1:0];
        end else begin
            n_node  = node1;
            n_disc  = disc1;
            n_image = '0;
            n_used  = '0;
            if (node1 >= NODE_W'(NODE_COUNT)) begin
                o_result.status = ST_EXHAUSTED;
            end else if (len > cap1) begin
                o_result.status = ST_TOO_LARGE;
            end else begin
                o_result.status       = ST_GRANT;
                o_result.grant_node   = node1[GNODE_W-1:0];
                o_result.grant_disc   = disc1;
                o_result.grant_length = len;
                n_used                = len;
            end
        end

        o_result.global_image = GLOBAL_W'(n_node) * GLOBAL_W'(DISCS_PER_NODE)
                              + GLOBAL_W'(n_disc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_node  <= '0;
            r_start_disc  <= '0;
            r_start_image <= '0;
            r_start_used  <= '0;
            r_node        <= '0;
            r_disc        <= '0;
            r_image       <= '0;
            r_used        <= '0;
        end else if (i_cfg_we) begin
            r_start_node  <= n_start_node;
            r_start_disc  <= n_start_disc;
            r_start_image <= n_start_image;
            r_start_used  <= n_start_used;
            // any start write reloads the whole cursor
            r_node        <= n_start_node;
            r_disc        <= n_start_disc;
            r_image       <= n_start_image;
            r_used        <= n_start_used;
        end else if (i_fire) begin
            r_node  <= n_node;
            r_disc  <= n_disc;
            r_image <= n_image;
            r_used  <= n_used;
        end
    end

endmodule

`default_nettype wire

// ===== design/sdsa_outq.sv =====
// two-entry result buffer: output register plus skid entry
`timescale 1ns / 1ps
`default_nettype none

module sdsa_outq
    import sdsa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic [1:0] r_cnt;
    t_result    r_q0;
    t_result    r_q1;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({i_push, pop})
                2'b10: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd0) begin
                        r_q0 <= i_data;
                    end else begin
                        r_q1 <= i_data;
                    end
                end
                2'b01: begin
                    r_cnt <= r_cnt - 2'd1;
                    r_q0  <= r_q1;
                end
                2'b11: begin
                    if (r_cnt == 2'd1) begin
                        r_q0 <= i_data;
                    end else begin
                        r_q0 <= r_q1;
                        r_q1 <= i_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/sequential_disc_space_allocator_top.sv =====
// throughput: one request per cycle while the result buffer is not full, one result per request
// the path is input register, one pass of allocation logic, two-entry result buffer
// a stalled receiver fills the result buffer, then the input register holds and ready falls
// synchronous active-low reset clears start registers and cursor to zero, buffers empty
`timescale 1ns / 1ps
`default_nettype none

module sequential_disc_space_allocator_top
    import sdsa_pkg::*;
#(
    parameter int unsigned NODE_COUNT     = 16,
    parameter int unsigned DISCS_PER_NODE = 64,
    parameter int unsigned SMALL_DISCS    = 32,
    parameter logic [63:0] CAPACITY_UNIT  = 64'd1000000000000
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    sdsa_req_if.sink                  i_req,
    sdsa_res_if.source                o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTES_W-1:0]   i_cfg_data
);

    logic               r_in_valid;
    logic [BYTES_W-1:0] r_in_len;
    logic               fire;
    logic               q_full;
    t_result            step_res;
    t_result            head;

    assign fire        = r_in_valid && !q_full;
    assign i_req.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_len <= i_req.request_length;
        end
    end

    sdsa_core #(
        .NODE_COUNT     (NODE_COUNT),
        .DISCS_PER_NODE (DISCS_PER_NODE),
        .SMALL_DISCS    (SMALL_DISCS),
        .CAPACITY_UNIT  (CAPACITY_UNIT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_len      (r_in_len),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (step_res)
    );

    sdsa_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (step_res),
        .o_full  (q_full),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (head)
    );

    assign o_res.status       = head.status;
    assign o_res.grant_node   = head.grant_node;
    assign o_res.grant_disc   = head.grant_disc;
    assign o_res.grant_image  = head.grant_image;
    assign o_res.grant_offset = head.grant_offset;
    assign o_res.grant_length = head.grant_length;
    assign o_res.global_image = head.global_image;

endmodule

`default_nettype wire
